FILE: rtl/core/smfc_pkg.sv
// Shared types, constants and register codes of the stream marker capture core.
`timescale 1ns / 1ps
`default_nettype none

package smfc_pkg;

    // Marker storage held by the four marker registers
    localparam int MARKER_BYTES     = 16;
    localparam int MIDX_W           = 4;    // index into the marker bytes
    localparam int CNT_W            = 5;    // burst count, up to MARKER_BYTES
    localparam int LEN_W            = 5;

    // Defaults for the top-level parameters
    localparam int MARKER_MAX_DEF   = 16;
    localparam int DEFAULT_KEEP_DEF = 1024;

    // Configuration port
    localparam int ADDR_W           = 5;
    localparam int DATA_W           = 32;
    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_MARKER0 = 3'd0;
    localparam logic [2:0] REG_MARKER1 = 3'd1;
    localparam logic [2:0] REG_MARKER2 = 3'd2;
    localparam logic [2:0] REG_MARKER3 = 3'd3;
    localparam logic [2:0] REG_LENGTH  = 3'd4;
    localparam logic [2:0] REG_KEEP    = 3'd5;
    localparam logic [2:0] REG_CAP     = 3'd6;

    typedef struct packed {
        logic       start_of_body;
        logic       byte_valid;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] captured_byte;
        logic       last_of_run;
        logic       capture_complete;
    } t_out_word;

    typedef struct packed {
        logic [MARKER_BYTES-1:0][7:0] marker;
        logic [LEN_W-1:0]             marker_length;
        logic [15:0]                  keep_count;
        logic [15:0]                  cap_count;
    } t_cfg;

    // Result burst handed from the search stage to the emitter
    typedef struct packed {
        logic             load;
        logic             multi;   // 1: replay marker bytes, 0: single byte
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] cnt;
        logic             done;    // limit reached with the last word
    } t_burst;

endpackage

`default_nettype wire

FILE: rtl/core/smfc_regs.sv
// APB-style configuration register file of the stream marker capture core.
`timescale 1ns / 1ps
`default_nettype none

module smfc_regs (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [smfc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [smfc_pkg::DATA_W-1:0] pwdata,
    output logic      [smfc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output smfc_pkg::t_cfg              o_cfg
);
    import smfc_pkg::*;

    logic [3:0][31:0] r_marker;
    logic [LEN_W-1:0] r_length;
    logic [15:0]      r_keep;
    logic [15:0]      r_cap;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= '0;
            r_length <= '0;
            r_keep   <= '0;
            r_cap    <= CAP_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MARKER0: r_marker[0] <= pwdata;
                REG_MARKER1: r_marker[1] <= pwdata;
                REG_MARKER2: r_marker[2] <= pwdata;
                REG_MARKER3: r_marker[3] <= pwdata;
                REG_LENGTH:  r_length    <= pwdata[LEN_W-1:0];
                REG_KEEP:    r_keep      <= pwdata[15:0];
                REG_CAP:     r_cap       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_MARKER0: prdata = r_marker[0];
            REG_MARKER1: prdata = r_marker[1];
            REG_MARKER2: prdata = r_marker[2];
            REG_MARKER3: prdata = r_marker[3];
            REG_LENGTH:  prdata = 32'(r_length);
            REG_KEEP:    prdata = 32'(r_keep);
            REG_CAP:     prdata = 32'(r_cap);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.marker        = r_marker;
    assign o_cfg.marker_length = r_length;
    assign o_cfg.keep_count    = r_keep;
    assign o_cfg.cap_count     = r_cap;

endmodule

`default_nettype wire

FILE: rtl/core/smfc_search.sv
// Input register, sliding window, marker compare and limit tracking.
`timescale 1ns / 1ps
`default_nettype none

module smfc_search #(
    parameter int MARKER_MAX   = smfc_pkg::MARKER_MAX_DEF,
    parameter int DEFAULT_KEEP = smfc_pkg::DEFAULT_KEEP_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  smfc_pkg::t_in_word      i_in_data,
    input  smfc_pkg::t_cfg          i_cfg,
    input  wire logic               i_free,
    output smfc_pkg::t_burst        o_burst
);
    import smfc_pkg::*;

    localparam int WIN  = (MARKER_MAX < MARKER_BYTES) ? MARKER_MAX : MARKER_BYTES;
    localparam int SEEN_W = $clog2(WIN + 1);
    localparam logic [LEN_W-1:0] WIN_L = LEN_W'(WIN);

    logic              r_in_v;
    t_in_word          r_in;
    logic [7:0]        r_win [WIN];
    logic [7:0]        n_win [WIN];
    logic [7:0]        w_sh  [WIN];
    logic [SEEN_W-1:0] r_seen, n_seen, seen_a, seen_inc;
    logic              r_srch, n_srch, srch_a;
    logic [15:0]       r_rem,  n_rem,  rem_a;
    logic [LEN_W-1:0]  len_eff;
    logic [15:0]       keep_eff, lim_srch;
    logic [CNT_W-1:0]  take;
    logic              fire, in_acc, hit;
    logic [WIN-1:0]    pos_ok;
    logic [MIDX_W-1:0] mi [WIN];

    assign fire       = r_in_v && i_free;
    assign o_in_stall = r_in_v && !fire;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Hold the accepted word until the emitter can take its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_acc) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    // Effective marker length and limits
    assign len_eff  = (i_cfg.marker_length > WIN_L) ? WIN_L : i_cfg.marker_length;
    assign keep_eff = (i_cfg.keep_count != 16'd0) ? i_cfg.keep_count : 16'(DEFAULT_KEEP);
    assign lim_srch = (keep_eff < i_cfg.cap_count) ? keep_eff : i_cfg.cap_count;

    // State as left by an optional re-arm
    always_comb begin
        if (r_in.start_of_body) begin
            seen_a = '0;
            srch_a = (len_eff != '0);
            rem_a  = srch_a ? lim_srch : i_cfg.cap_count;
        end else begin
            seen_a = r_seen;
            srch_a = r_srch;
            rem_a  = r_rem;
        end
    end

    assign seen_inc = (seen_a < SEEN_W'(WIN)) ? seen_a + SEEN_W'(1) : seen_a;

    // Shift the new byte in, newest at position 0
    always_comb begin
        w_sh[0] = r_in.data_byte;
        for (int k = 1; k < WIN; k++) begin
            w_sh[k] = r_win[k-1];
        end
    end

    // Compare each window position against its marker byte
    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            mi[k]     = MIDX_W'(len_eff - LEN_W'(k) - LEN_W'(1));
            pos_ok[k] = (LEN_W'(k) >= len_eff) || (w_sh[k] == i_cfg.marker[mi[k]]);
        end
    end

    assign hit  = (&pos_ok) && (LEN_W'(seen_inc) >= len_eff);
    assign take = (rem_a < 16'(len_eff)) ? CNT_W'(rem_a) : CNT_W'(len_eff);

    // Advance search state and form the result burst
    always_comb begin
        n_win   = r_win;
        n_seen  = r_seen;
        n_srch  = r_srch;
        n_rem   = r_rem;
        o_burst = '0;
        o_burst.data_byte = r_in.data_byte;
        if (fire) begin
            n_seen = seen_a;
            n_srch = srch_a;
            n_rem  = rem_a;
            if (r_in.byte_valid && (rem_a != 16'd0)) begin
                if (srch_a && (len_eff != '0)) begin
                    n_win  = w_sh;
                    n_seen = seen_inc;
                    if (hit) begin
                        n_srch        = 1'b0;
                        n_rem         = rem_a - 16'(take);
                        o_burst.load  = 1'b1;
                        o_burst.multi = 1'b1;
                        o_burst.cnt   = take;
                        o_burst.done  = (rem_a == 16'(take));
                    end
                end else begin
                    n_srch        = 1'b0;
                    n_rem         = rem_a - 16'd1;
                    o_burst.load  = 1'b1;
                    o_burst.cnt   = CNT_W'(1);
                    o_burst.done  = (rem_a == 16'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_srch <= 1'b0;
            r_rem  <= '0;
        end else begin
            r_seen <= n_seen;
            r_srch <= n_srch;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    // A found marker ends the search
    a_hit_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_burst.load && o_burst.multi) |=> !r_srch)
        else $error("search still armed after marker hit");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(WIN))
        else $error("window fill count beyond window");

    a_burst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_burst.load |-> (o_burst.cnt != '0) && (LEN_W'(o_burst.cnt) <= WIN_L))
        else $error("result burst length out of range");

endmodule

`default_nettype wire

FILE: rtl/core/smfc_emit.sv
// Result emitter: replays marker bytes or passes a single byte, one word a cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module smfc_emit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  smfc_pkg::t_burst        i_burst,
    input  smfc_pkg::t_cfg          i_cfg,
    output logic                    o_free,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output smfc_pkg::t_out_word     o_out_data
);
    import smfc_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic [MIDX_W-1:0] r_idx;
    logic              r_multi;
    logic              r_done;
    logic [7:0]        r_byte;
    logic              out_acc;
    logic              last;

    assign o_out_valid = (r_cnt != '0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign last        = (r_cnt == CNT_W'(1));
    assign o_free      = !o_out_valid || (last && !i_out_stall);

    // Load a new burst or advance through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_burst.load) begin
            r_cnt <= i_burst.cnt;
        end else if (out_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst.load) begin
            r_idx   <= '0;
            r_multi <= i_burst.multi;
            r_done  <= i_burst.done;
            r_byte  <= i_burst.data_byte;
        end else if (out_acc) begin
            r_idx   <= r_idx + MIDX_W'(1);
        end
    end

    assign o_out_data.captured_byte    = r_multi ? i_cfg.marker[r_idx] : r_byte;
    assign o_out_data.last_of_run      = last;
    assign o_out_data.capture_complete = r_done && last;

    // Never overwrite a burst that still has words to deliver
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_burst.load |-> ((r_cnt == '0) || (last && !i_out_stall)))
        else $error("burst loaded over pending words");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_multi) |->
            ((CNT_W + 1)'(r_idx) + (CNT_W + 1)'(r_cnt) <= (CNT_W + 1)'(MARKER_BYTES)))
        else $error("marker replay index out of range");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && last && !i_burst.load) |=> !o_out_valid)
        else $error("emitter still valid after last word");

endmodule

`default_nettype wire

FILE: rtl/core/stream_marker_find_and_capture_core.sv
// Top level of the stream marker find and capture core.
`timescale 1ns / 1ps
`default_nettype none

// Takes one body byte per input word and searches a sliding window for the
// configured marker (up to 16 bytes, clamped to MARKER_MAX). On a match the
// marker bytes are delivered, then every following byte, until min(keep, cap)
// bytes are out (keep 0 selects DEFAULT_KEEP); an empty marker captures up to
// cap bytes from the first byte. Nothing is captured until a word with
// start_of_body set. Each input word passes the input register and the compare
// stage; one word per cycle is sustained while the output does not stall and no
// marker is replayed, with one result word per captured byte. On a hit the marker
// bytes are replayed from the marker registers while the input side stalls.
// Registers must be written with the block idle; the block does not enforce it.
module stream_marker_find_and_capture_core #(
    parameter int MARKER_MAX   = smfc_pkg::MARKER_MAX_DEF,
    parameter int DEFAULT_KEEP = smfc_pkg::DEFAULT_KEEP_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  smfc_pkg::t_in_word          i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output smfc_pkg::t_out_word         o_out_data,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [smfc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [smfc_pkg::DATA_W-1:0] pwdata,
    output logic      [smfc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import smfc_pkg::*;

    t_cfg   cfg;
    t_burst burst;
    logic   emit_free;

    smfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    smfc_search #(
        .MARKER_MAX   (MARKER_MAX),
        .DEFAULT_KEEP (DEFAULT_KEEP)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_free     (emit_free),
        .o_burst    (burst)
    );

    smfc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_burst     (burst),
        .i_cfg       (cfg),
        .o_free      (emit_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
